// ===== rtl/speed_pid_drive_command_unit_assert.svh =====
// Assertion macros used by the RTL control file spdc_ctrl.
`ifndef SPEED_PID_DRIVE_COMMAND_UNIT_ASSERT_SVH
`define SPEED_PID_DRIVE_COMMAND_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPDC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spdc assertion failed");
`define SPDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spdc assertion failed");
`else
`define SPDC_ASSERT_IMPL(label, ante, cons)
`define SPDC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/spdc_pkg.sv =====
package spdc_pkg;

    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 24;
    localparam int ILIM_W  = 15;
    localparam int DRIVE_W = 21;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int DIFF_W  = 17;
    localparam int INTEG_W = 32;
    localparam int ACC_W   = 42;
    localparam int SUM_W   = 43;
    localparam int PROD_W  = 62;
    localparam int Y_W     = 30;
    localparam int Q_W     = 22;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 24'd19661;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 24'd1311;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN  = 24'd983040;
    localparam logic [ILIM_W-1:0]  RST_INTEG_LIMIT = 15'd1000;
    localparam logic [DRIVE_W-1:0] RST_DRIVE_LIMIT = 21'd65536;

    // round(x / 1500) = floor((x + 750) / 4 / 375), 1/375 as M / 2^39
    localparam logic [SUM_W-1:0]   HALF_DIV    = 43'd750;
    localparam logic [30:0]        RECIP_M     = 31'd1466015504;
    localparam int                 RECIP_SHIFT = 39;
    localparam logic [DRIVE_W-1:0] DEAD_BAND   = 21'd6;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [ILIM_W-1:0]  integ_limit;
        logic [DRIVE_W-1:0] drive_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        MUL_KI,
        MUL_KP,
        MUL_KD,
        MUL_RECIP
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULI,
        ST_INT,
        ST_PROP,
        ST_DERIV,
        ST_MAG,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     int_upd;
        logic     sum_add;
        logic     mag_load;
        logic     out_load;
    } t_cmd;

endpackage

// ===== rtl/spdc_in_if.sv =====
interface spdc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [spdc_pkg::SPEED_W-1:0] target_speed;
    logic signed [spdc_pkg::SPEED_W-1:0] measured_speed;

    modport source(output valid, output target_speed, output measured_speed, input ready);
    modport sink(input valid, input target_speed, input measured_speed, output ready);
endinterface

// ===== rtl/spdc_out_if.sv =====
interface spdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [spdc_pkg::DRIVE_W-1:0]  drive_level;
    logic                          drive_forward;

    modport source(output valid, output drive_level, output drive_forward, input ready);
    modport sink(input valid, input drive_level, input drive_forward, output ready);
endinterface

// ===== rtl/spdc_regs.sv =====
module spdc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [spdc_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [spdc_pkg::CFG_W-1:0]   i_cfg_data,
    output spdc_pkg::t_cfg               o_cfg
);

    spdc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= spdc_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain  <= spdc_pkg::RST_INTEG_GAIN;
            r_cfg.deriv_gain  <= spdc_pkg::RST_DERIV_GAIN;
            r_cfg.integ_limit <= spdc_pkg::RST_INTEG_LIMIT;
            r_cfg.drive_limit <= spdc_pkg::RST_DRIVE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spdc_pkg::REG_PROP_GAIN: begin
                    r_cfg.prop_gain <= i_cfg_data;
                end
                spdc_pkg::REG_INTEG_GAIN: begin
                    r_cfg.integ_gain <= i_cfg_data;
                end
                spdc_pkg::REG_DERIV_GAIN: begin
                    r_cfg.deriv_gain <= i_cfg_data;
                end
                spdc_pkg::REG_INTEG_LIMIT: begin
                    r_cfg.integ_limit <= i_cfg_data[spdc_pkg::ILIM_W-1:0];
                end
                spdc_pkg::REG_DRIVE_LIMIT: begin
                    r_cfg.drive_limit <= i_cfg_data[spdc_pkg::DRIVE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/spdc_dp.sv =====
module spdc_dp (
    input  logic                                i_clk,
    input  spdc_pkg::t_cfg                      i_cfg,
    input  spdc_pkg::t_cmd                      i_cmd,
    input  logic                                i_rst_n,
    input  logic signed [spdc_pkg::SPEED_W-1:0] i_target_speed,
    input  logic signed [spdc_pkg::SPEED_W-1:0] i_measured_speed,
    output logic [spdc_pkg::DRIVE_W-1:0]        o_drive_level,
    output logic                                o_drive_forward
);

    logic signed [spdc_pkg::SPEED_W-1:0] r_err;
    logic signed [spdc_pkg::SPEED_W-1:0] r_prev_err;
    logic signed [spdc_pkg::DIFF_W-1:0]  r_diff;
    logic signed [spdc_pkg::INTEG_W-1:0] r_integral;
    logic signed [spdc_pkg::PROD_W-1:0]  r_prod;
    logic signed [spdc_pkg::SUM_W-1:0]   r_sum;
    logic [spdc_pkg::Y_W-1:0]            r_y;
    logic                                r_big;
    logic                                r_neg;
    logic [spdc_pkg::DRIVE_W-1:0]        r_level;
    logic                                r_fwd;

    logic signed [spdc_pkg::SPEED_W-1:0] n_err;
    logic signed [spdc_pkg::DIFF_W-1:0]  n_diff;
    logic signed [31:0]                  mul_a;
    logic signed [31:0]                  mul_b;
    logic signed [63:0]                  mul_p;
    logic signed [spdc_pkg::ACC_W-1:0]   acc;
    logic signed [spdc_pkg::ACC_W-1:0]   ilim;
    logic signed [spdc_pkg::ACC_W-1:0]   acc_c;
    logic [spdc_pkg::SUM_W-1:0]          mag;
    logic [spdc_pkg::SUM_W-1:0]          mag_r;
    logic [spdc_pkg::Q_W-1:0]            quot;
    logic [spdc_pkg::DRIVE_W-1:0]        lim;

    always_comb begin
        n_err  = i_target_speed - i_measured_speed;
        n_diff = {n_err[spdc_pkg::SPEED_W-1], n_err}
               - {r_prev_err[spdc_pkg::SPEED_W-1], r_prev_err};

        case (i_cmd.mul_sel)
            spdc_pkg::MUL_KI: begin
                mul_a = $signed({8'd0, i_cfg.integ_gain});
                mul_b = 32'(r_err);
            end
            spdc_pkg::MUL_KP: begin
                mul_a = $signed({8'd0, i_cfg.prop_gain});
                mul_b = 32'(r_err);
            end
            spdc_pkg::MUL_KD: begin
                mul_a = $signed({8'd0, i_cfg.deriv_gain});
                mul_b = 32'(r_diff);
            end
            spdc_pkg::MUL_RECIP: begin
                mul_a = $signed({2'd0, r_y});
                mul_b = $signed({1'b0, spdc_pkg::RECIP_M});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;

        acc  = spdc_pkg::ACC_W'(r_integral) + r_prod[spdc_pkg::ACC_W-1:0];
        ilim = $signed({11'd0, i_cfg.integ_limit, 16'd0});
        if (acc > ilim) begin
            acc_c = ilim;
        end else if (acc < -ilim) begin
            acc_c = -ilim;
        end else begin
            acc_c = acc;
        end

        mag   = r_sum[spdc_pkg::SUM_W-1] ? 43'(-r_sum) : 43'(r_sum);
        mag_r = mag + spdc_pkg::HALF_DIV;

        quot = r_prod[spdc_pkg::RECIP_SHIFT+spdc_pkg::Q_W-1:spdc_pkg::RECIP_SHIFT];
        if (r_big || (quot > {1'b0, i_cfg.drive_limit})) begin
            lim = i_cfg.drive_limit;
        end else begin
            lim = quot[spdc_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev_err <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_prev_err <= n_err;
            end
            if (i_cmd.int_upd) begin
                r_integral <= acc_c[spdc_pkg::INTEG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_err  <= n_err;
            r_diff <= n_diff;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[spdc_pkg::PROD_W-1:0];
        end
        if (i_cmd.int_upd) begin
            r_sum <= spdc_pkg::SUM_W'(acc_c);
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + r_prod[spdc_pkg::SUM_W-1:0];
        end
        if (i_cmd.mag_load) begin
            r_neg <= r_sum[spdc_pkg::SUM_W-1];
            r_y   <= mag_r[spdc_pkg::Y_W+1:2];
            r_big <= |mag_r[spdc_pkg::SUM_W-1:32];
        end
        if (i_cmd.out_load) begin
            if (lim > spdc_pkg::DEAD_BAND) begin
                r_level <= lim;
                r_fwd   <= !r_neg;
            end else begin
                r_level <= '0;
                r_fwd   <= 1'b0;
            end
        end
    end

    assign o_drive_level   = r_level;
    assign o_drive_forward = r_fwd;

endmodule

// ===== rtl/spdc_ctrl.sv =====
`include "speed_pid_drive_command_unit_assert.svh"

module spdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spdc_pkg::t_cmd o_cmd
);

    spdc_pkg::t_state r_state;
    spdc_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spdc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.mul_sel = spdc_pkg::MUL_KI;
        o_in_ready  = 1'b0;
        out_free    = !r_out_valid || i_out_ready;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            spdc_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = spdc_pkg::ST_MULI;
                end
            end
            spdc_pkg::ST_MULI: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spdc_pkg::MUL_KI;
                n_state       = spdc_pkg::ST_INT;
            end
            spdc_pkg::ST_INT: begin
                o_cmd.int_upd = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spdc_pkg::MUL_KP;
                n_state       = spdc_pkg::ST_PROP;
            end
            spdc_pkg::ST_PROP: begin
                o_cmd.sum_add = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spdc_pkg::MUL_KD;
                n_state       = spdc_pkg::ST_DERIV;
            end
            spdc_pkg::ST_DERIV: begin
                o_cmd.sum_add = 1'b1;
                n_state       = spdc_pkg::ST_MAG;
            end
            spdc_pkg::ST_MAG: begin
                o_cmd.mag_load = 1'b1;
                n_state        = spdc_pkg::ST_DIV;
            end
            spdc_pkg::ST_DIV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = spdc_pkg::MUL_RECIP;
                n_state       = spdc_pkg::ST_OUT;
            end
            spdc_pkg::ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = spdc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `SPDC_ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == spdc_pkg::ST_MULI)
    `SPDC_ASSERT_IMPL(a_busy_not_ready, r_state != spdc_pkg::ST_IDLE, !o_in_ready)
    `SPDC_ASSERT_NEXT(a_out_hold, (r_state == spdc_pkg::ST_OUT) && r_out_valid && !i_out_ready, (r_state == spdc_pkg::ST_OUT) && r_out_valid)
    `SPDC_ASSERT_IMPL(a_load_needs_free, o_cmd.out_load, !r_out_valid || i_out_ready)

endmodule

// ===== rtl/speed_pid_drive_command_unit.sv =====
// Channel   Role     Payload
// i_in      sink     target_speed[15:0] s, measured_speed[15:0] s
// o_out     source   drive_level[20:0], drive_forward
// i_cfg_*   write    i_cfg_idx[2:0], i_cfg_data[23:0]
//
// Each item takes the transfer and seven steps through the
// single shared 32x32 multiplier used four times (ki, kp, kd, 1/1500).
// The result is registered on leaving ST_OUT, after the states MULI, INT, PROP, DERIV, MAG and DIV.
// A new item is taken once the previous one has moved to the output register.
// A stalled result holds in the output register; a second result waits behind it.
// Synchronous active-low reset clears integral, previous error and output valid; config registers take their defaults.
module speed_pid_drive_command_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spdc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [spdc_pkg::CFG_W-1:0]  i_cfg_data,
    spdc_in_if.sink                     i_in,
    spdc_out_if.source                  o_out
);

    spdc_pkg::t_cfg cfg;
    spdc_pkg::t_cmd cmd;

    spdc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    spdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    spdc_dp u_dp (
        .i_clk            (i_clk),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_rst_n          (i_rst_n),
        .i_target_speed   (i_in.target_speed),
        .i_measured_speed (i_in.measured_speed),
        .o_drive_level    (o_out.drive_level),
        .o_drive_forward  (o_out.drive_forward)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int     RANDOM_ITEMS = 530;
    localparam int     QUIET_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 20;
    localparam longint SCALE_DIV    = 1500;
    localparam longint DEAD_Q16     = 6;

    localparam logic [spdc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_KNOWN,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [spdc_pkg::DRIVE_W-1:0] level;
        logic                         fwd;
    } t_drive_cmd;

    typedef struct packed {
        t_row_kind                    kind;
        logic [spdc_pkg::IDX_W-1:0]   idx;
        logic [spdc_pkg::CFG_W-1:0]   data;
        logic [spdc_pkg::SPEED_W-1:0] tgt;
        logic [spdc_pkg::SPEED_W-1:0] meas;
        logic [spdc_pkg::DRIVE_W-1:0] level;
        logic                         fwd;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [41] = '{
        '{ROW_KNOWN, '0, '0, 16'h0000, 16'h0000, 21'd0, 1'b0},
        '{ROW_KNOWN, '0, '0, 16'h7fff, 16'h0000, 21'd65536, 1'b1},
        '{ROW_KNOWN, '0, '0, 16'h8000, 16'h0000, 21'd65536, 1'b0},
        '{ROW_ITEM, '0, '0, 16'h0000, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0000, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h7fff, 16'h8000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h7fff, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h8000, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DRIVE_LIMIT, 24'd0, '0, '0, '0, '0},
        '{ROW_KNOWN, '0, '0, 16'd12345, 16'hf830, 21'd0, 1'b0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_LIMIT, 24'd0, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_GAIN, 24'd0, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DERIV_GAIN, 24'd0, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_PROP_GAIN, 24'd9750, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DRIVE_LIMIT, 24'd65536, '0, '0, '0, '0},
        '{ROW_KNOWN, '0, '0, 16'h0001, 16'h0000, 21'd7, 1'b1},
        '{ROW_KNOWN, '0, '0, 16'h0000, 16'h0001, 21'd7, 1'b0},
        '{ROW_CFG, spdc_pkg::REG_PROP_GAIN, 24'd9749, '0, '0, '0, '0},
        '{ROW_KNOWN, '0, '0, 16'h0001, 16'h0000, 21'd0, 1'b0},
        '{ROW_KNOWN, '0, '0, 16'h0000, 16'h0001, 21'd0, 1'b0},
        '{ROW_CFG, spdc_pkg::REG_PROP_GAIN, 24'hffffff, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_GAIN, 24'hffffff, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DERIV_GAIN, 24'hffffff, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_LIMIT, 24'hffffff, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DRIVE_LIMIT, 24'hffffff, '0, '0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h7fff, 16'h8000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h7fff, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h8000, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0064, 16'hff9c, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0000, 16'h0000, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_LIMIT, 24'd1, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_PROP_GAIN, 24'd0, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_DERIV_GAIN, 24'd0, '0, '0, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_GAIN, 24'd65536, '0, '0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0005, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0005, 16'h0000, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0005, 16'h0000, '0, '0},
        '{ROW_CFG, spdc_pkg::REG_INTEG_LIMIT, 24'd0, '0, '0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'h0005, 16'h0000, '0, '0},
        '{ROW_CFG, REG_UNUSED, 24'hffffff, '0, '0, '0, '0},
        '{ROW_ITEM, '0, '0, 16'hfffb, 16'h0000, '0, '0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [spdc_pkg::IDX_W-1:0]  i_cfg_idx;
    logic [spdc_pkg::CFG_W-1:0]  i_cfg_data;

    spdc_in_if  in_ch ();
    spdc_out_if out_ch ();

    speed_pid_drive_command_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #4 i_clk = ~i_clk;

    logic [spdc_pkg::GAIN_W-1:0]  kp_q;
    logic [spdc_pkg::GAIN_W-1:0]  ki_q;
    logic [spdc_pkg::GAIN_W-1:0]  kd_q;
    logic [spdc_pkg::ILIM_W-1:0]  ilim_q;
    logic [spdc_pkg::DRIVE_W-1:0] dlim_q;
    longint                       integ_q16;
    longint                       err_prev_q;

    t_drive_cmd pending_drive[$];
    int         mismatches = 0;
    int         burst_left = 0;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    function automatic t_drive_cmd predict_drive(input logic [spdc_pkg::SPEED_W-1:0] tgt,
                                                 input logic [spdc_pkg::SPEED_W-1:0] meas);
        logic signed [spdc_pkg::SPEED_W-1:0] err;
        longint                              e;
        longint                              lim;
        longint                              acc;
        longint                              sum;
        longint                              mag;
        longint                              scaled;
        longint                              dlim;
        t_drive_cmd                          cmd;
        err = tgt - meas;
        e = longint'(err);
        lim = longint'(ilim_q) * 65536;
        acc = integ_q16 + longint'(ki_q) * e;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        integ_q16 = acc;
        sum = longint'(kp_q) * e + acc + longint'(kd_q) * (e - err_prev_q);
        err_prev_q = e;
        mag = (sum < 0) ? -sum : sum;
        mag = (mag + SCALE_DIV / 2) / SCALE_DIV;
        scaled = (sum < 0) ? -mag : mag;
        dlim = longint'(dlim_q);
        if (scaled > dlim) scaled = dlim;
        if (scaled < -dlim) scaled = -dlim;
        cmd.level = '0;
        cmd.fwd = 1'b0;
        if (scaled > DEAD_Q16) begin
            cmd.level = scaled[spdc_pkg::DRIVE_W-1:0];
            cmd.fwd = 1'b1;
        end else if (scaled < -DEAD_Q16) begin
            cmd.level = spdc_pkg::DRIVE_W'(-scaled);
        end
        return cmd;
    endfunction

    function automatic logic [spdc_pkg::CFG_W-1:0] pick_reg_value(
            input logic [spdc_pkg::IDX_W-1:0] idx);
        int                         pick;
        logic [spdc_pkg::CFG_W-1:0] v;
        pick = $urandom_range(0, 5);
        v = spdc_pkg::CFG_W'($urandom);
        case (pick)
            0: v = '0;
            1: v = '1;
            2, 3: begin
                if (idx == spdc_pkg::REG_DRIVE_LIMIT && pick == 2) v = 24'd1048576;
            end
            default: begin
                case (idx)
                    spdc_pkg::REG_INTEG_LIMIT: v = spdc_pkg::CFG_W'($urandom_range(0, 2000));
                    spdc_pkg::REG_DRIVE_LIMIT: v = spdc_pkg::CFG_W'($urandom_range(0, 1048576));
                    default:                   v = spdc_pkg::CFG_W'($urandom_range(0, 65536));
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [spdc_pkg::SPEED_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'hffff;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7fff;
        endcase
    endfunction

    task automatic pick_speeds(output logic [spdc_pkg::SPEED_W-1:0] tgt,
                               output logic [spdc_pkg::SPEED_W-1:0] meas);
        int mode;
        mode = $urandom_range(0, 19);
        tgt = spdc_pkg::SPEED_W'($urandom);
        meas = spdc_pkg::SPEED_W'($urandom);
        if (mode < 10) begin
            meas = tgt + spdc_pkg::SPEED_W'($urandom_range(0, 40)) - 16'd20;
        end else if (mode >= 15 && mode < 17) begin
            tgt = pick_extreme();
            meas = pick_extreme();
        end else if (mode >= 17) begin
            meas = tgt + spdc_pkg::SPEED_W'($urandom_range(0, 4000)) - 16'd2000;
        end
    endtask

    task automatic apply_reg(input logic [spdc_pkg::IDX_W-1:0] idx,
                             input logic [spdc_pkg::CFG_W-1:0] data);
        case (idx)
            spdc_pkg::REG_PROP_GAIN:   kp_q = data[spdc_pkg::GAIN_W-1:0];
            spdc_pkg::REG_INTEG_GAIN:  ki_q = data[spdc_pkg::GAIN_W-1:0];
            spdc_pkg::REG_DERIV_GAIN:  kd_q = data[spdc_pkg::GAIN_W-1:0];
            spdc_pkg::REG_INTEG_LIMIT: ilim_q = data[spdc_pkg::ILIM_W-1:0];
            spdc_pkg::REG_DRIVE_LIMIT: dlim_q = data[spdc_pkg::DRIVE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [spdc_pkg::IDX_W-1:0] idx,
                             input logic [spdc_pkg::CFG_W-1:0] data);
        in_ch.valid <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic [spdc_pkg::SPEED_W-1:0] tgt,
                             input logic [spdc_pkg::SPEED_W-1:0] meas,
                             input bit known, input t_drive_cmd known_cmd);
        int         gap;
        t_drive_cmd cmd;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
        end
        in_ch.valid <= 1'b1;
        in_ch.target_speed <= tgt;
        in_ch.measured_speed <= meas;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        cmd = predict_drive(tgt, meas);
        pending_drive.push_back(known ? known_cmd : cmd);
    endtask

    initial begin : stimulus
        int                           sent;
        int                           phase_left;
        logic [spdc_pkg::SPEED_W-1:0] tgt;
        logic [spdc_pkg::SPEED_W-1:0] meas;
        t_drive_cmd                   want;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.target_speed <= '0;
        in_ch.measured_speed <= '0;
        kp_q = spdc_pkg::RST_PROP_GAIN;
        ki_q = spdc_pkg::RST_INTEG_GAIN;
        kd_q = spdc_pkg::RST_DERIV_GAIN;
        ilim_q = spdc_pkg::RST_INTEG_LIMIT;
        dlim_q = spdc_pkg::RST_DRIVE_LIMIT;
        integ_q16 = 0;
        err_prev_q = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
            end else begin
                want.level = DIRECTED_ROWS[r].level;
                want.fwd = DIRECTED_ROWS[r].fwd;
                send_item(DIRECTED_ROWS[r].tgt, DIRECTED_ROWS[r].meas,
                          DIRECTED_ROWS[r].kind == ROW_KNOWN, want);
            end
        end

        sent = 0;
        want = '0;
        while (sent < RANDOM_ITEMS) begin
            write_reg(spdc_pkg::REG_PROP_GAIN, pick_reg_value(spdc_pkg::REG_PROP_GAIN));
            write_reg(spdc_pkg::REG_INTEG_GAIN, pick_reg_value(spdc_pkg::REG_INTEG_GAIN));
            write_reg(spdc_pkg::REG_DERIV_GAIN, pick_reg_value(spdc_pkg::REG_DERIV_GAIN));
            write_reg(spdc_pkg::REG_INTEG_LIMIT, pick_reg_value(spdc_pkg::REG_INTEG_LIMIT));
            write_reg(spdc_pkg::REG_DRIVE_LIMIT, pick_reg_value(spdc_pkg::REG_DRIVE_LIMIT));
            if ($urandom_range(0, 3) == 0)
                write_reg(spdc_pkg::IDX_W'($urandom_range(5, 7)), spdc_pkg::CFG_W'($urandom));
            phase_left = $urandom_range(40, 90);
            while (phase_left > 0 && sent < RANDOM_ITEMS) begin
                pick_speeds(tgt, meas);
                send_item(tgt, meas, 1'b0, want);
                phase_left--;
                sent++;
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : drive_sink
        int stretch_no;
        int span;
        int mode_sel;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        stretch_no = 0;
        forever begin
            if (stretch_no == 3 || $urandom_range(0, 9) == 0) begin
                // hold off long enough to back up the input
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(40, 90)) @(posedge i_clk);
            end else begin
                mode_sel = $urandom_range(0, 2);
                span = $urandom_range(20, 150);
                repeat (span) begin
                    case (mode_sel)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
            stretch_no++;
        end
    end

    always @(posedge i_clk) begin : drive_check
        t_drive_cmd want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_drive.size() == 0) begin
                report_mismatch("drive_level with no transfer pending", out_ch.drive_level, 0);
            end else begin
                want = pending_drive.pop_front();
                if (out_ch.drive_level !== want.level)
                    report_mismatch("drive_level", out_ch.drive_level, want.level);
                if (out_ch.drive_forward !== want.fwd)
                    report_mismatch("drive_forward", out_ch.drive_forward, want.fwd);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (in_ch.valid && in_ch.ready)
                    || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== speed_pid_drive_command_unit.f =====
+incdir+rtl
rtl/spdc_pkg.sv
rtl/spdc_in_if.sv
rtl/spdc_out_if.sv
rtl/spdc_regs.sv
rtl/spdc_dp.sv
rtl/spdc_ctrl.sv
rtl/speed_pid_drive_command_unit.sv
tb/testbench.sv
